FILE: rtl/core/battery_health_estimator_assert.svh
// ----------------------------------------------------------------------------
// Battery health estimator assertion macros
// Shared property forms for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef BATTERY_HEALTH_ESTIMATOR_ASSERT_SVH
`define BATTERY_HEALTH_ESTIMATOR_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define BHE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define BHE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// The consequent holds in the cycle after reset is applied.
`define BHE_ASSERT_RESET(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) rst |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/bhe_pkg.sv
// ----------------------------------------------------------------------------
// Battery health estimator package
// Widths, curve and level tables, and the types shared by the core modules.
// ----------------------------------------------------------------------------
package bhe_pkg;

  localparam int CUR_WIDTH       = 16;
  localparam int MAG_WIDTH       = 16;
  localparam int ACC_WIDTH       = 41;
  localparam int CAP_WIDTH       = 40;
  localparam int SHOWN_WIDTH     = 16;
  localparam int SOH_WIDTH       = 14;
  localparam int LEVEL_WIDTH     = 3;
  localparam int CYCLE_WIDTH_DEF = 16;
  localparam int QUEUE_DEPTH     = 4;
  localparam int APB_ADDR_WIDTH  = 4;
  localparam int APB_DATA_WIDTH  = 64;

  localparam logic [CAP_WIDTH-1:0] CAP_RESET = 40'd10800000;
  localparam logic [0:0] REG_CAPACITY = 1'b0;

  localparam logic [SOH_WIDTH-1:0] SOH_FULL = 14'd10000;
  localparam logic [11:0] CURVE_END = 12'd3000;
  localparam logic [7:0]  CURVE_STEP = 8'd200;
  localparam logic [7:0]  CURVE_ROUND = 8'd199;
  localparam logic [5:0]  SEG_RECIP = 6'd41;
  localparam logic [12:0] DEC_RECIP = 13'd5243;

  localparam logic [SOH_WIDTH-1:0] CURVE_PTS [16] = '{
    14'd10000, 14'd9330, 14'd8670, 14'd8000, 14'd7340, 14'd6670, 14'd6000, 14'd5330,
    14'd4760,  14'd4000, 14'd3330, 14'd2670, 14'd2000, 14'd1330, 14'd670,  14'd0
  };

  localparam logic [SOH_WIDTH-1:0] LEVEL_THR [8] = '{
    14'd8580, 14'd7140, 14'd5710, 14'd4290, 14'd2860, 14'd1430, 14'd500, 14'd0
  };

  typedef enum logic {
    ACC_IDLE,
    ACC_DIV
  } acc_state_t;

  typedef struct packed {
    logic                 valid;
    logic [MAG_WIDTH-1:0] mag;
  } qitem_t;

  typedef struct packed {
    logic valid;
    logic save;
  } commit_t;

  function automatic logic [SOH_WIDTH-1:0] curve_point(input logic [3:0] idx);
    return CURVE_PTS[idx];
  endfunction

  function automatic logic [LEVEL_WIDTH-1:0] level_of(input logic [SOH_WIDTH-1:0] soh);
    logic [LEVEL_WIDTH-1:0] lvl;
    lvl = '0;
    for (int i = 7; i >= 0; i--) begin
      if (soh >= LEVEL_THR[i]) begin
        lvl = LEVEL_WIDTH'(7 - i);
      end
    end
    return lvl;
  endfunction

endpackage

FILE: rtl/core/bhe_front.sv
// ----------------------------------------------------------------------------
// Battery health estimator front end
// Takes current samples, keeps only the discharge magnitude, and queues it.
// ----------------------------------------------------------------------------
module bhe_front import bhe_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        sample_valid,
  output logic                        sample_stall,
  input  logic signed [CUR_WIDTH-1:0] current_ma,
  input  logic                        pop,
  output qitem_t                      head
);

  localparam int PtrW = $clog2(QUEUE_DEPTH);
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  logic [MAG_WIDTH-1:0] mem [QUEUE_DEPTH];
  logic [PtrW-1:0]      wr_ptr;
  logic [PtrW-1:0]      rd_ptr;
  logic [CntW-1:0]      count;
  logic [MAG_WIDTH-1:0] mag;
  logic                 push;
  logic                 do_pop;

  assign sample_stall = (count == CntW'(QUEUE_DEPTH));
  assign push         = sample_valid && !sample_stall;
  assign do_pop       = pop && (count != '0);
  assign head.valid   = (count != '0);
  assign head.mag     = mem[rd_ptr];

  always_comb begin
    if (current_ma[CUR_WIDTH-1]) begin
      mag = MAG_WIDTH'(~current_ma + 1'b1);
    end else begin
      mag = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= mag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= PtrW'(wr_ptr + 1'b1);
      end
      if (do_pop) begin
        rd_ptr <= PtrW'(rd_ptr + 1'b1);
      end
      case ({push, do_pop})
        2'b10:   count <= CntW'(count + 1'b1);
        2'b01:   count <= CntW'(count - 1'b1);
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: rtl/core/bhe_accum.sv
// ----------------------------------------------------------------------------
// Battery health estimator charge accumulator
// Adds discharge to the remainder, removes whole capacities, counts cycles.
// ----------------------------------------------------------------------------
module bhe_accum import bhe_pkg::*; #(
  parameter int CYCLE_WIDTH = CYCLE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [CAP_WIDTH-1:0]   capacity,
  input  qitem_t                 head,
  output logic                   pop,
  input  logic                   adv,
  output commit_t                commit,
  output logic [CYCLE_WIDTH-1:0] counter_next
);

  localparam logic [ACC_WIDTH-1:0]   AccMax   = {ACC_WIDTH{1'b1}};
  localparam logic [CYCLE_WIDTH-1:0] CycMax   = {CYCLE_WIDTH{1'b1}};
  localparam int                     CntW     = $clog2(ACC_WIDTH + 1);
  localparam logic [CntW-1:0]        DivSteps = CntW'(ACC_WIDTH);

  acc_state_t             state;
  acc_state_t             state_next;
  logic [ACC_WIDTH-1:0]   remainder;
  logic [ACC_WIDTH-1:0]   remainder_next;
  logic [CYCLE_WIDTH-1:0] counter;
  logic [ACC_WIDTH-1:0]   div_q;
  logic [ACC_WIDTH-1:0]   div_q_next;
  logic [ACC_WIDTH-1:0]   div_r;
  logic [ACC_WIDTH-1:0]   div_r_next;
  logic [CntW-1:0]        div_cnt;
  logic [CntW-1:0]        div_cnt_next;

  logic [ACC_WIDTH:0]     sum_wide;
  logic [ACC_WIDTH-1:0]   sum;
  logic [ACC_WIDTH-1:0]   cap_ext;
  logic [ACC_WIDTH-1:0]   cap_twice;
  logic                   cap_zero;
  logic                   need_div;
  logic [ACC_WIDTH-1:0]   fast_n;
  logic [ACC_WIDTH-1:0]   fast_rem;
  logic [ACC_WIDTH-1:0]   shifted;
  logic [ACC_WIDTH-1:0]   commit_n;
  logic [ACC_WIDTH:0]     ctr_sum;

  always_comb begin
    sum_wide  = {1'b0, remainder} + (ACC_WIDTH + 1)'(head.mag);
    sum       = sum_wide[ACC_WIDTH] ? AccMax : sum_wide[ACC_WIDTH-1:0];
    cap_ext   = {1'b0, capacity};
    cap_twice = {capacity, 1'b0};
    cap_zero  = (capacity == '0);
    need_div  = !cap_zero && (sum >= cap_twice);
    if (cap_zero || (sum < cap_ext)) begin
      fast_n   = '0;
      fast_rem = sum;
    end else begin
      fast_n   = ACC_WIDTH'(1);
      fast_rem = sum - cap_ext;
    end
    shifted = {div_r[ACC_WIDTH-2:0], div_q[ACC_WIDTH-1]};
  end

  always_comb begin
    state_next     = state;
    remainder_next = remainder;
    div_q_next     = div_q;
    div_r_next     = div_r;
    div_cnt_next   = div_cnt;
    pop            = 1'b0;
    commit.valid   = 1'b0;
    commit_n       = '0;
    case (state)
      ACC_IDLE: begin
        if (head.valid && need_div) begin
          pop          = 1'b1;
          div_q_next   = sum;
          div_r_next   = '0;
          div_cnt_next = DivSteps;
          state_next   = ACC_DIV;
        end else if (head.valid && adv) begin
          pop            = 1'b1;
          commit.valid   = 1'b1;
          commit_n       = fast_n;
          remainder_next = fast_rem;
        end
      end
      ACC_DIV: begin
        if (div_cnt != '0) begin
          div_cnt_next = CntW'(div_cnt - 1'b1);
          if (shifted >= cap_ext) begin
            div_r_next = shifted - cap_ext;
            div_q_next = {div_q[ACC_WIDTH-2:0], 1'b1};
          end else begin
            div_r_next = shifted;
            div_q_next = {div_q[ACC_WIDTH-2:0], 1'b0};
          end
        end else if (adv) begin
          commit.valid   = 1'b1;
          commit_n       = div_q;
          remainder_next = div_r;
          state_next     = ACC_IDLE;
        end
      end
      default: begin
        state_next = ACC_IDLE;
      end
    endcase
    ctr_sum = (ACC_WIDTH + 1)'(counter) + (ACC_WIDTH + 1)'(commit_n);
    if (!commit.valid) begin
      counter_next = counter;
    end else if (ctr_sum > (ACC_WIDTH + 1)'(CycMax)) begin
      counter_next = CycMax;
    end else begin
      counter_next = CYCLE_WIDTH'(ctr_sum);
    end
    commit.save = (counter_next != counter);
  end

  always_ff @(posedge clk) begin
    div_q   <= div_q_next;
    div_r   <= div_r_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ACC_IDLE;
      remainder <= '0;
      counter   <= '0;
      div_cnt   <= '0;
    end else begin
      state     <= state_next;
      remainder <= remainder_next;
      counter   <= counter_next;
      div_cnt   <= div_cnt_next;
    end
  end

endmodule

FILE: rtl/core/bhe_soh.sv
// ----------------------------------------------------------------------------
// Battery health estimator health curve
// Maps the cycle count through the health curve and level table to a result.
// ----------------------------------------------------------------------------
module bhe_soh import bhe_pkg::*; #(
  parameter int CYCLE_WIDTH = CYCLE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  commit_t                commit,
  input  logic [CYCLE_WIDTH-1:0] counter,
  output logic                   adv,
  output logic                   result_valid,
  input  logic                   result_stall,
  output logic [SHOWN_WIDTH-1:0] cycle_count,
  output logic [SOH_WIDTH-1:0]   soh_hundredths,
  output logic [LEVEL_WIDTH-1:0] health_level,
  output logic                   save_request
);

  logic [32:0]            ctr_wide;
  logic [SHOWN_WIDTH-1:0] shown_in;
  logic [8:0]             c_div8;
  logic [14:0]            seg_prod;

  logic                   v1;
  logic                   v2;
  logic                   v3;
  logic [SHOWN_WIDTH-1:0] shown1;
  logic [SHOWN_WIDTH-1:0] shown2;
  logic [SHOWN_WIDTH-1:0] shown3;
  logic                   save1;
  logic                   save2;
  logic                   save3;
  logic                   end1;
  logic                   end2;
  logic [11:0]            c1;
  logic [3:0]             seg1;

  logic [11:0]            seg_base;
  logic [7:0]             frac;
  logic [SOH_WIDTH-1:0]   pt_hi;
  logic [SOH_WIDTH-1:0]   pt_lo;
  logic [9:0]             drop;
  logic [17:0]            scaled;
  logic [SOH_WIDTH-1:0]   hi2;
  logic [17:0]            scaled2;

  logic [27:0]            dec_prod;
  logic [9:0]             dec;
  logic [SOH_WIDTH-1:0]   soh3;
  logic [SOH_WIDTH-1:0]   soh_hold;

  assign adv = !result_valid || !result_stall;

  always_comb begin
    ctr_wide = 33'(counter);
    shown_in = (ctr_wide > 33'h0FFFF) ? {SHOWN_WIDTH{1'b1}} : ctr_wide[SHOWN_WIDTH-1:0];
    c_div8   = ctr_wide[11:3];
    seg_prod = 15'(c_div8 * SEG_RECIP);
  end

  always_comb begin
    seg_base = 12'(seg1 * CURVE_STEP);
    frac     = 8'(c1 - seg_base);
    pt_hi    = curve_point(seg1);
    pt_lo    = curve_point(4'(seg1 + 1'b1));
    drop     = 10'(pt_hi - pt_lo);
    scaled   = 18'(drop * frac) + 18'(CURVE_ROUND);
  end

  always_comb begin
    dec_prod = 28'(scaled2[17:3] * DEC_RECIP);
    dec      = dec_prod[26:17];
    soh3     = end2 ? '0 : SOH_WIDTH'(hi2 - SOH_WIDTH'(dec));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      shown1         <= shown_in;
      save1          <= commit.save;
      end1           <= (ctr_wide >= 33'(CURVE_END));
      c1             <= ctr_wide[11:0];
      seg1           <= seg_prod[13:10];
      shown2         <= shown1;
      save2          <= save1;
      end2           <= end1;
      hi2            <= pt_hi;
      scaled2        <= scaled;
      shown3         <= shown2;
      save3          <= save2;
      soh_hold       <= soh3;
      cycle_count    <= shown3;
      soh_hundredths <= soh_hold;
      health_level   <= level_of(soh_hold);
      save_request   <= save3;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      result_valid <= 1'b0;
    end else if (adv) begin
      v1           <= commit.valid;
      v2           <= v1;
      v3           <= v2;
      result_valid <= v3;
    end
  end

endmodule

FILE: rtl/core/battery_health_estimator.sv
// ----------------------------------------------------------------------------
// Battery health estimator
// Counts equivalent full discharge cycles and reports state of health.
//
//   Channel   Handshake                    Payload
//   sample    sample_valid / sample_stall  current_ma
//   result    result_valid / result_stall  cycle_count, soh_hundredths,
//                                          health_level, save_request
//   config    psel/penable/pwrite/pready   paddr, pwdata, prdata
//
// One sample is taken per cycle while the queue has room, and one result leaves per
// cycle while result_stall is low. A sample's result passes from the queue through
// the curve pipeline to the result registers. When the held charge reaches twice the
// capacity, a 41-step restoring divider holds that sample while the sample queue fills.
// Reset is synchronous; the capacity returns to 10800000 mA*s and all counts
// clear. A stalled result freezes the curve pipeline and then the queue.
// ----------------------------------------------------------------------------
module battery_health_estimator import bhe_pkg::*; #(
  parameter int CYCLE_WIDTH = CYCLE_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        sample_valid,
  output logic                        sample_stall,
  input  logic signed [CUR_WIDTH-1:0] current_ma,
  output logic                        result_valid,
  input  logic                        result_stall,
  output logic [SHOWN_WIDTH-1:0]      cycle_count,
  output logic [SOH_WIDTH-1:0]        soh_hundredths,
  output logic [LEVEL_WIDTH-1:0]      health_level,
  output logic                        save_request,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [APB_ADDR_WIDTH-1:0]   paddr,
  input  logic [APB_DATA_WIDTH-1:0]   pwdata,
  output logic [APB_DATA_WIDTH-1:0]   prdata,
  output logic                        pready
);

  `include "battery_health_estimator_assert.svh"

  logic [CAP_WIDTH-1:0]   capacity;
  logic                   cfg_write;
  qitem_t                 head;
  logic                   pop;
  logic                   adv;
  commit_t                commit;
  logic [CYCLE_WIDTH-1:0] counter_next;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[3] == REG_CAPACITY) ? APB_DATA_WIDTH'(capacity) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_write && (paddr[3] == REG_CAPACITY)) begin
      capacity <= pwdata[CAP_WIDTH-1:0];
    end
  end

  bhe_front u_front (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .current_ma   (current_ma),
    .pop          (pop),
    .head         (head)
  );

  bhe_accum #(
    .CYCLE_WIDTH (CYCLE_WIDTH)
  ) u_accum (
    .clk          (clk),
    .rst          (rst),
    .capacity     (capacity),
    .head         (head),
    .pop          (pop),
    .adv          (adv),
    .commit       (commit),
    .counter_next (counter_next)
  );

  bhe_soh #(
    .CYCLE_WIDTH (CYCLE_WIDTH)
  ) u_soh (
    .clk            (clk),
    .rst            (rst),
    .commit         (commit),
    .counter        (counter_next),
    .adv            (adv),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .cycle_count    (cycle_count),
    .soh_hundredths (soh_hundredths),
    .health_level   (health_level),
    .save_request   (save_request)
  );

  `BHE_ASSERT_SAME(a_fresh_full, result_valid && (cycle_count == '0), (soh_hundredths == SOH_FULL) && (health_level == 3'd7), "A fresh battery must report full health.")
  `BHE_ASSERT_SAME(a_save_nonzero, result_valid && save_request, cycle_count != '0, "A save request came with a zero cycle count.")
  `BHE_ASSERT_SAME(a_soh_range, result_valid, soh_hundredths <= SOH_FULL, "Health exceeds one hundred percent.")
  `BHE_ASSERT_RESET(a_cap_reset, capacity == CAP_RESET, "Capacity did not return to its reset value.")

endmodule

FILE: test/bhe_checker.sv
// ----------------------------------------------------------------------------
// Battery health estimator checker
// Watches the sample, result and register channels of the estimator. It keeps
// its own charge and cycle state and works out the expected health report for
// every sample transaction. Reports are compared in order, field by field, and
// the number of failures and of reports still owed go back to the testbench.
// ----------------------------------------------------------------------------
module bhe_checker
  import bhe_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        sample_valid,
  input  logic                        sample_stall,
  input  logic signed [CUR_WIDTH-1:0] current_ma,
  input  logic                        result_valid,
  input  logic                        result_stall,
  input  logic [SHOWN_WIDTH-1:0]      cycle_count,
  input  logic [SOH_WIDTH-1:0]        soh_hundredths,
  input  logic [LEVEL_WIDTH-1:0]      health_level,
  input  logic                        save_request,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [APB_ADDR_WIDTH-1:0]   paddr,
  input  logic [APB_DATA_WIDTH-1:0]   pwdata,
  output int                          failures,
  output int                          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [APB_ADDR_WIDTH-1:0] CAPACITY_ADDR = {REG_CAPACITY, 3'b000};
  localparam int SEGMENT_CYCLES = 200;
  localparam int CURVE_LAST = 3000;

  typedef struct packed {
    logic [SHOWN_WIDTH-1:0] cycles;
    logic [SOH_WIDTH-1:0]   health;
    logic [LEVEL_WIDTH-1:0] grade;
    logic                   save;
  } health_report_t;

  logic [ACC_WIDTH-1:0]   charge_left;
  logic [SHOWN_WIDTH-1:0] cycles_done;
  logic [CAP_WIDTH-1:0]   capacity;
  health_report_t         owed_reports[$];

  function automatic logic [SOH_WIDTH-1:0] health_of(input logic [SHOWN_WIDTH-1:0] n);
    int seg;
    int frac;
    int upper;
    int lower;
    int drop;
    if (int'(n) >= CURVE_LAST) return CURVE_PTS[15];
    seg = int'(n) / SEGMENT_CYCLES;
    frac = int'(n) % SEGMENT_CYCLES;
    upper = int'(CURVE_PTS[seg]);
    lower = int'(CURVE_PTS[seg + 1]);
    drop = ((upper - lower) * frac + SEGMENT_CYCLES - 1) / SEGMENT_CYCLES;
    return SOH_WIDTH'(upper - drop);
  endfunction

  function automatic logic [LEVEL_WIDTH-1:0] grade_of(input logic [SOH_WIDTH-1:0] health);
    for (int i = 0; i < 8; i++) begin
      if (health >= LEVEL_THR[i]) return LEVEL_WIDTH'(7 - i);
    end
    return '0;
  endfunction

  task automatic account_sample(input logic signed [CUR_WIDTH-1:0] cur,
                                output health_report_t report);
    logic [16:0]            drain_mas;
    logic [ACC_WIDTH:0]     total;
    logic [ACC_WIDTH-1:0]   whole;
    logic [SHOWN_WIDTH-1:0] prior;
    prior = cycles_done;
    drain_mas = cur[CUR_WIDTH-1] ? 17'(17'h10000 - {1'b0, cur}) : '0;
    total = (ACC_WIDTH + 1)'(charge_left) + (ACC_WIDTH + 1)'(drain_mas);
    charge_left = total[ACC_WIDTH] ? '1 : total[ACC_WIDTH-1:0];
    if (capacity != '0) begin
      whole = charge_left / {1'b0, capacity};
      charge_left = charge_left % {1'b0, capacity};
      if (whole > ACC_WIDTH'(16'hFFFF - cycles_done)) begin
        cycles_done = '1;
      end else begin
        cycles_done = cycles_done + whole[SHOWN_WIDTH-1:0];
      end
    end
    report.cycles = cycles_done;
    report.health = health_of(cycles_done);
    report.grade = grade_of(report.health);
    report.save = (cycles_done != prior);
  endtask

  function automatic int field_bad(input string name, input longint want, input longint got);
    if (want == got) return 0;
    $error("%s: expected %0d, got %0d", name, want, got);
    return 1;
  endfunction

  always @(posedge clk) begin
    health_report_t want;
    health_report_t seen;
    int bad;
    bad = 0;
    if (rst) begin
      charge_left = '0;
      cycles_done = '0;
      capacity = CAP_RESET;
      owed_reports.delete();
      failures <= 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == CAPACITY_ADDR) begin
        capacity = pwdata[CAP_WIDTH-1:0];
      end
      if (result_valid && !result_stall) begin
        seen = '{cycle_count, soh_hundredths, health_level, save_request};
        if (owed_reports.size() == 0) begin
          $error("Report transaction with none expected: cycle_count %0d", cycle_count);
          bad++;
        end else begin
          want = owed_reports.pop_front();
          bad += field_bad("cycle_count", want.cycles, seen.cycles);
          bad += field_bad("soh_hundredths", want.health, seen.health);
          bad += field_bad("health_level", want.grade, seen.grade);
          bad += field_bad("save_request", want.save, seen.save);
        end
      end
      if (sample_valid && !sample_stall) begin
        account_sample(current_ma, want);
        owed_reports.push_back(want);
      end
      failures <= failures + bad;
    end
    pending <= owed_reports.size();
  end

endmodule

FILE: test/battery_health_estimator_tb.sv
// ----------------------------------------------------------------------------
// Battery health estimator testbench
// Drives current samples through the estimator under several capacity
// settings, from the reset value through the widest and narrowest values,
// so the cycle count sweeps the whole health curve and ends saturated.
// Both channels idle in random bursts; the checker grades every report.
// ----------------------------------------------------------------------------
module battery_health_estimator_tb import bhe_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [APB_ADDR_WIDTH-1:0] CAPACITY_ADDR = {REG_CAPACITY, 3'b000};
  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE_CYCLES = 64;

  logic clk = 1'b0;
  logic rst;
  logic sample_valid;
  logic sample_stall;
  logic signed [CUR_WIDTH-1:0] current_ma;
  logic result_valid;
  logic result_stall;
  logic [SHOWN_WIDTH-1:0] cycle_count;
  logic [SOH_WIDTH-1:0] soh_hundredths;
  logic [LEVEL_WIDTH-1:0] health_level;
  logic save_request;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_ADDR_WIDTH-1:0] paddr;
  logic [APB_DATA_WIDTH-1:0] pwdata;
  logic [APB_DATA_WIDTH-1:0] prdata;
  logic pready;

  int failures;
  int pending;
  int cycles_run = 0;
  int stall_left;
  logic jitter;

  always #10 clk = ~clk;

  battery_health_estimator dut (
    .clk(clk), .rst(rst),
    .sample_valid(sample_valid), .sample_stall(sample_stall), .current_ma(current_ma),
    .result_valid(result_valid), .result_stall(result_stall),
    .cycle_count(cycle_count), .soh_hundredths(soh_hundredths),
    .health_level(health_level), .save_request(save_request),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  bhe_checker u_checker (
    .clk(clk), .rst(rst),
    .sample_valid(sample_valid), .sample_stall(sample_stall), .current_ma(current_ma),
    .result_valid(result_valid), .result_stall(result_stall),
    .cycle_count(cycle_count), .soh_hundredths(soh_hundredths),
    .health_level(health_level), .save_request(save_request),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata), .failures(failures), .pending(pending)
  );

  always @(posedge clk) begin
    cycles_run <= cycles_run + 1;
    if (cycles_run > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst || !jitter) begin
      result_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else if (stall_left == 1) begin
      result_stall <= 1'b0;
      stall_left <= 0;
    end else if ($urandom_range(0, 7) == 0) begin
      result_stall <= 1'b1;
      stall_left <= $urandom_range(1, 11);
    end
  end

  function automatic logic signed [CUR_WIDTH-1:0] pick_current();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return CUR_WIDTH'(-int'($urandom_range(1, 32768)));
    if (roll < 80) return CUR_WIDTH'($urandom_range(1, 32767));
    if (roll < 90) return CUR_WIDTH'($urandom);
    if (roll < 94) return 16'sh8000;
    if (roll < 97) return 16'sh7FFF;
    return '0;
  endfunction

  task automatic send_sample(input logic signed [CUR_WIDTH-1:0] cur);
    if (jitter && $urandom_range(0, 3) == 0) begin
      sample_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    sample_valid <= 1'b1;
    current_ma <= cur;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
  endtask

  task automatic wait_idle();
    sample_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_WIDTH-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CAPACITY_ADDR;
    pwdata <= APB_DATA_WIDTH'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic run_phase(input logic [CAP_WIDTH-1:0] value, input int count,
                           input bit idling);
    write_capacity(value);
    for (int k = 0; k < count; k++) begin
      if (k % 50 == 0) jitter <= idling && ($urandom_range(0, 3) != 0);
      send_sample(pick_current());
    end
    wait_idle();
  endtask

  initial begin
    logic signed [CUR_WIDTH-1:0] corners[$];
    corners = '{16'sh8000, 16'sh7FFF, 16'sh0000, 16'shFFFF, 16'sh0001, 16'sh8001,
                16'sh7FFE, 16'sh5555, 16'shAAAA, 16'sh00FF, 16'shFF00, 16'sh8000,
                16'sh8000, 16'shC000, 16'sh4000, 16'sh8000};
    rst <= 1'b1;
    jitter <= 1'b0;
    sample_valid <= 1'b0;
    current_ma <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (corners[i]) send_sample(corners[i]);
    wait_idle();
    run_phase(40'd32768, 200, 1'b1);
    run_phase(40'd3000, 700, 1'b1);
    run_phase(40'hFF_FFFF_FFFF, 100, 1'b1);
    run_phase(40'd0, 100, 1'b1);
    run_phase(40'd997, 200, 1'b1);
    run_phase(40'd1, 150, 1'b0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/bhe_pkg.sv
rtl/core/bhe_front.sv
rtl/core/bhe_accum.sv
rtl/core/bhe_soh.sv
rtl/core/battery_health_estimator.sv
test/bhe_checker.sv
test/battery_health_estimator_tb.sv
